>>> src/ihf_pkg.sv
// Shared constants and types for the isotonic histogram fit unit.
package ihf_pkg;
    localparam int MAX_BINS = 256;
    localparam int IDX_W    = $clog2(MAX_BINS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int RAW_W    = 16;
    localparam int FIT_W    = 32;
    localparam int SUM_W    = 40;
    localparam int FRAC_W   = 16;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [IDX_W-1:0]  bin_index;
        logic [RAW_W-1:0]  bin_value;
        logic              last_bin;
    } t_req;

    typedef struct packed {
        logic [FIT_W-1:0]  fitted_value;
        logic              index_valid;
    } t_rsp;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_cmd;

    typedef struct packed {
        logic              done;
        logic [FIT_W-1:0]  quotient;
    } t_div_rsp;
endpackage

>>> src/ihf_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ihf_req_if import ihf_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ihf_rsp_if import ihf_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/ihf_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ihf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/ihf_div.sv
// Restoring divider: pool sum over pool length, one quotient bit per cycle.
module ihf_div import ihf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_cmd i_cmd,
    output t_div_rsp o_rsp
);
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    w_trial;

    assign w_trial = {r_rem, r_quo[SUM_W-1]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_quo  <= i_cmd.dividend;
                r_den  <= i_cmd.divisor;
                r_rem  <= '0;
                r_step <= STEP_W'(SUM_W - 1);
            end else if (r_busy) begin
                if (!w_trial[CNT_W]) begin
                    r_rem <= w_trial[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[CNT_W-2:0], r_quo[SUM_W-1]};
                    r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                end
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[FIT_W-1:0];

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_den != '0))
        else $error("divide by zero pool length");
endmodule

>>> src/isotonic_histogram_fit_unit.sv
// Isotonic histogram fit unit: top level with request/response channels and APB config.
//
// Requests arrive on i_req (valid/ready). A load (req_type 0) stores a raw
// bin; a load with last_bin set fixes the bin count at index+1 and runs a
// pool-adjacent-violators fit over the loaded bins. A read (req_type 1)
// returns one response on o_rsp: the fitted Q16.16 value and index_valid.
// A load without last_bin leaves the unit idle. A read issues the fitted-bin
// memory read while idle, waits for the registered read data in S_READ_WAIT
// and loads the response register in S_READ_OUT.
// A fit walks the bins through the fitted-bin memory: each scan step reads,
// waits for the read data and compares (S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK),
// each bin fetches and stores its raw value (S_NEW_RD, S_NEW_WAIT) and then
// advances (S_NEXT), and each pool runs a serial divide and then writes each
// pooled bin in S_FILL. Ready stays low meanwhile.
// The register increasing_mode lies at APB address 0 and is sampled at fit
// start. After reset the fitted table reads as zero through per-bin valid
// bits, bin count is zero, and no clearing pass is needed.
// When the receiver stalls, the response holds; loads and fits go on, and a
// following read waits in its last cycle until the response is taken.
module isotonic_histogram_fit_unit import ihf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ihf_req_if.sink     i_req,
    ihf_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ_WAIT, S_READ_OUT,
        S_NEW_RD, S_NEW_WAIT, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK,
        S_DIV_GO, S_DIV_WAIT, S_FILL, S_NEXT
    } t_state;

    t_state           r_state;
    logic             r_mode;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_pool_sum;
    logic [SUM_W-1:0] r_sum;
    logic [IDX_W-1:0] r_cur;
    logic [IDX_W-1:0] r_scan;
    logic [CNT_W-1:0] r_len;
    logic [IDX_W-1:0] r_fill;
    logic [CNT_W-1:0] r_left;
    logic [FIT_W-1:0] r_mean;
    logic             r_fit_mode;
    logic [CNT_W-1:0] r_done_n;
    logic [MAX_BINS-1:0] r_fvalid;
    logic             r_rsp_valid;
    t_rsp             r_rsp;
    logic             r_rd_ok;

    logic             w_raw_we;
    logic [IDX_W-1:0] w_raw_raddr;
    logic [RAW_W-1:0] w_raw_rdata;
    logic             w_fit_we;
    logic [IDX_W-1:0] w_fit_waddr;
    logic [FIT_W-1:0] w_fit_wdata;
    logic [IDX_W-1:0] w_fit_raddr;
    logic [FIT_W-1:0] w_fit_rdata;
    logic             r_rd_vld;
    logic [FIT_W-1:0] w_fit_val;
    logic [FIT_W-1:0] w_new_val;
    logic [SUM_W+CNT_W-1:0] w_prod;
    logic             w_edge;
    t_div_cmd         w_div_cmd;
    t_div_rsp         w_div_rsp;
    logic             w_req_fire;
    logic             w_apb_wr;
    logic             w_rsp_load;

    assign pready   = 1'b1;
    assign prdata   = {31'd0, r_mode};
    assign w_apb_wr = psel && penable && pwrite && pready;

    assign i_req.ready   = (r_state == S_IDLE);
    assign w_req_fire    = i_req.valid && i_req.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;
    assign w_rsp_load    = (r_state == S_READ_OUT) && (!r_rsp_valid || o_rsp.ready);

    assign w_raw_we = w_req_fire && (i_req.payload.req_type == REQ_LOAD);
    assign w_raw_raddr = r_cur;

    assign w_fit_val = r_rd_vld ? w_fit_rdata : '0;
    assign w_new_val = {w_raw_rdata, {FRAC_W{1'b0}}};
    assign w_prod    = w_fit_val * r_len;
    assign w_edge    = r_fit_mode ? (({1'b0, r_cur} + r_len) >= r_count)
                                  : (r_len > {1'b0, r_cur});

    always_comb begin
        w_fit_raddr = r_scan;
        if (r_state == S_IDLE) begin
            w_fit_raddr = i_req.payload.bin_index;
        end
        w_fit_we    = (r_state == S_FILL) || (r_state == S_NEW_WAIT);
        w_fit_waddr = (r_state == S_FILL) ? r_fill : r_cur;
        w_fit_wdata = (r_state == S_FILL) ? r_mean : w_new_val;
    end

    assign w_div_cmd.start    = (r_state == S_DIV_GO);
    assign w_div_cmd.dividend = r_sum;
    assign w_div_cmd.divisor  = r_len;

    ihf_ram #(.WIDTH(RAW_W), .DEPTH(MAX_BINS)) u_raw (
        .i_clk   (i_clk),
        .i_we    (w_raw_we),
        .i_waddr (i_req.payload.bin_index),
        .i_wdata (i_req.payload.bin_value),
        .i_raddr (w_raw_raddr),
        .o_rdata (w_raw_rdata)
    );

    ihf_ram #(.WIDTH(FIT_W), .DEPTH(MAX_BINS)) u_fit (
        .i_clk   (i_clk),
        .i_we    (w_fit_we),
        .i_waddr (w_fit_waddr),
        .i_wdata (w_fit_wdata),
        .i_raddr (w_fit_raddr),
        .o_rdata (w_fit_rdata)
    );

    ihf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_pool_sum  <= '0;
            r_fvalid    <= '0;
            r_rsp_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (w_apb_wr && (paddr == 2'd0)) begin
                r_mode <= pwdata[0];
            end
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (w_fit_we) begin
                r_fvalid[w_fit_waddr] <= 1'b1;
            end
            r_rd_vld <= r_fvalid[w_fit_raddr] && !(w_fit_we && w_fit_waddr == w_fit_raddr);
            case (r_state)
                S_IDLE: begin
                    if (w_req_fire) begin
                        if (i_req.payload.req_type == REQ_READ) begin
                            r_rd_ok <= {1'b0, i_req.payload.bin_index} < r_count;
                            r_scan  <= i_req.payload.bin_index;
                            r_state <= S_READ_WAIT;
                        end else if (i_req.payload.last_bin) begin
                            r_count    <= {1'b0, i_req.payload.bin_index} + 1'b1;
                            r_fit_mode <= r_mode;
                            r_cur      <= r_mode ? i_req.payload.bin_index : '0;
                            r_done_n   <= '0;
                            r_state    <= S_NEW_RD;
                        end
                    end
                end
                S_READ_WAIT: r_state <= S_READ_OUT;
                S_READ_OUT: begin
                    if (w_rsp_load) begin
                        r_rsp.fitted_value <= r_rd_ok ? w_fit_val : '0;
                        r_rsp.index_valid  <= r_rd_ok;
                        r_state            <= S_IDLE;
                    end
                end
                S_NEW_RD: r_state <= S_NEW_WAIT;
                S_NEW_WAIT: begin
                    r_sum   <= {8'd0, w_new_val};
                    r_len   <= CNT_W'(1);
                    r_scan  <= r_fit_mode ? r_cur + 1'b1 : r_cur - 1'b1;
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: r_state <= S_SCAN_WAIT;
                S_SCAN_WAIT: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (w_edge || (w_prod >= {{CNT_W{1'b0}}, r_sum})) begin
                        r_state <= S_DIV_GO;
                    end else begin
                        r_sum   <= r_sum + {8'd0, w_fit_val};
                        r_len   <= r_len + 1'b1;
                        r_scan  <= r_fit_mode ? r_scan + 1'b1 : r_scan - 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_mean     <= w_div_rsp.quotient;
                        r_pool_sum <= r_sum;
                        r_fill     <= r_cur;
                        r_left     <= r_len;
                        r_state    <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_fill <= r_fit_mode ? r_fill + 1'b1 : r_fill - 1'b1;
                    r_left <= r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_done_n + 1'b1 == r_count) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_done_n <= r_done_n + 1'b1;
                        r_cur    <= r_fit_mode ? r_cur - 1'b1 : r_cur + 1'b1;
                        r_state  <= S_NEW_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_req_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_req_fire && r_state != S_IDLE))
        else $error("request accepted outside idle");
    a_fill_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_FILL && r_left == '0))
        else $error("pool fill with zero length");
    a_pool_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_SCAN_CHK && r_len > r_count))
        else $error("pool longer than bin count");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.payload)))
        else $error("response dropped or changed while stalled");
endmodule

>>> test/tb_isotonic_histogram_fit_unit.sv
// Testbench for the isotonic histogram fit unit: random loads, fits and reads checked against a predictor.
module tb_isotonic_histogram_fit_unit;
    import ihf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 1000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ihf_req_if req_ch ();
    ihf_rsp_if rsp_ch ();

    isotonic_histogram_fit_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [RAW_W-1:0] model_raw [MAX_BINS];
    logic [FIT_W-1:0] model_fit [MAX_BINS];
    int               model_count;
    logic             model_up;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   errors;
    int   idle_pct;
    bit   rx_hold;
    bit   rx_trigger;
    int   quiet_cycles;
    bit   timed_out;

    function automatic void fit_bins(input int n);
        logic [63:0] s;
        logic [FIT_W-1:0] mean;
        int i;
        int j;
        int k;
        if (!model_up) begin
            for (i = 0; i < n; i++) begin
                model_fit[i] = {model_raw[i], 16'h0};
                s = model_fit[i];
                j = i - 1;
                while (j >= 0 && 64'(model_fit[j]) * 64'(i - j) < s) begin
                    s += model_fit[j];
                    j--;
                end
                mean = FIT_W'(s / 64'(i - j));
                for (k = j + 1; k <= i; k++) model_fit[k] = mean;
            end
        end else begin
            for (i = n - 1; i >= 0; i--) begin
                model_fit[i] = {model_raw[i], 16'h0};
                s = model_fit[i];
                j = i + 1;
                while (j < n && 64'(model_fit[j]) * 64'(j - i) < s) begin
                    s += model_fit[j];
                    j++;
                end
                mean = FIT_W'(s / 64'(j - i));
                for (k = i; k < j; k++) model_fit[k] = mean;
            end
        end
    endfunction

    function automatic void predict_request(input t_req r);
        t_rsp e;
        if (r.req_type == REQ_LOAD) begin
            model_raw[r.bin_index] = r.bin_value;
            if (r.last_bin) begin
                model_count = int'(r.bin_index) + 1;
                fit_bins(model_count);
            end
        end else begin
            if (int'(r.bin_index) < model_count) begin
                e.fitted_value = model_fit[r.bin_index];
                e.index_valid  = 1'b1;
            end else begin
                e.fitted_value = '0;
                e.index_valid  = 1'b0;
            end
            expected_rsps.push_back(e);
        end
    endfunction

    function automatic t_req make_req(input logic rt, input int idx, input int val,
                                      input logic lst);
        t_req r;
        r.req_type  = rt;
        r.bin_index = IDX_W'(idx);
        r.bin_value = RAW_W'(val);
        r.last_bin  = lst;
        return r;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 4))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 15);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Load bins 0..n-1 (last one marked), then read a mix of indexes.
    task automatic queue_histogram(input int n, input int reads);
        int i;
        for (i = 0; i < n; i++)
            pending_reqs.push_back(make_req(REQ_LOAD, i, rand_value(), i == n - 1));
        for (i = 0; i < reads; i++)
            pending_reqs.push_back(make_req(REQ_READ,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, n - 1),
                $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_up = data[0];
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predict_request(req_ch.payload);
                void'(pending_reqs.pop_front());
            end
            if ((req_ch.valid && !req_ch.ready)) begin
                // hold the offered request
            end else if (pending_reqs.size() > (req_ch.valid && req_ch.ready ? 0 : 0)
                         && pending_reqs.size() != 0
                         && $urandom_range(0, 99) >= idle_pct) begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= pending_reqs[0];
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response fitted_value=%h index_valid=%b",
                             $time, rsp_ch.payload.fitted_value,
                             rsp_ch.payload.index_valid);
                    errors++;
                end else begin
                    if (rsp_ch.payload.fitted_value !== expected_rsps[0].fitted_value) begin
                        $display("%0t: fitted_value expected %h actual %h", $time,
                                 expected_rsps[0].fitted_value,
                                 rsp_ch.payload.fitted_value);
                        errors++;
                    end
                    if (rsp_ch.payload.index_valid !== expected_rsps[0].index_valid) begin
                        $display("%0t: index_valid expected %b actual %b", $time,
                                 expected_rsps[0].index_valid,
                                 rsp_ch.payload.index_valid);
                        errors++;
                    end
                    void'(expected_rsps.pop_front());
                end
            end
            rsp_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            timed_out = 1'b1;
            $display("isotonic_histogram_fit_unit test failed");
            $finish;
        end
    end

    initial begin
        int hold_left;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                hold_left--;
                if (hold_left <= 0) rx_hold = 1'b0;
            end
            if (rx_trigger) begin
                rx_trigger = 1'b0;
                rx_hold    = 1'b1;
                hold_left  = 300;
            end
        end
    end

    initial begin
        int i;
        int n;
        errors       = 0;
        idle_pct     = 37;
        rx_hold      = 1'b0;
        rx_trigger   = 1'b0;
        quiet_cycles = 0;
        timed_out    = 1'b0;
        model_count  = 0;
        model_up     = 1'b0;
        for (i = 0; i < MAX_BINS; i++) begin
            model_raw[i] = '0;
            model_fit[i] = '0;
        end
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reads before any fit are out of range
        pending_reqs.push_back(make_req(REQ_READ, 0, 65535, 1'b1));
        pending_reqs.push_back(make_req(REQ_READ, 255, 0, 1'b0));
        pending_reqs.push_back(make_req(REQ_LOAD, 0, 65535, 1'b1));
        pending_reqs.push_back(make_req(REQ_READ, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(REQ_READ, 1, 0, 1'b0));
        for (i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(REQ_LOAD, i, (i == 2) ? 65535 : i * 3, i == 5));
        for (i = 0; i < 7; i++)
            pending_reqs.push_back(make_req(REQ_READ, i, 0, 1'b0));
        wait_drained();

        apb_write(2'd0, 32'h1);
        for (i = 0; i < 5; i++)
            pending_reqs.push_back(make_req(REQ_LOAD, i, 65535 - i * 1000, i == 4));
        for (i = 0; i < 5; i++)
            pending_reqs.push_back(make_req(REQ_READ, i, 0, 1'b0));
        wait_drained();

        // long receiver hold while requests keep coming
        apb_write(2'd0, 32'h0);
        queue_histogram(4, 20);
        rx_trigger = 1'b1;
        wait_drained();

        // one full-size fit, driven with no idling
        apb_write(2'd0, 32'h1);
        idle_pct = 0;
        queue_histogram(256, 10);
        pending_reqs.push_back(make_req(REQ_READ, 255, 0, 1'b0));
        wait_drained();
        idle_pct = 37;

        for (n = 0; n < 3; n++) begin
            apb_write(2'd0, {31'h0, 1'($urandom_range(0, 1))});
            for (i = 0; i < 3; i++)
                queue_histogram($urandom_range(1, 12), $urandom_range(2, 8));
            wait_drained();
        end

        if (errors == 0)
            $display("isotonic_histogram_fit_unit test passed");
        else
            $display("isotonic_histogram_fit_unit test failed");
        $finish;
    end
endmodule
